### hdl/rmpe_pkg.sv
// Types and constants for the RAR MAC PDU encoder.
// Standalone package; used by rar_mac_pdu_encoder_core.
package rmpe_pkg;

  localparam int unsigned CountWidth  = 13;
  localparam int unsigned IdxWidth    = 4;
  localparam int unsigned MaxBytes    = 12;
  localparam int unsigned RarLength   = 8;
  localparam int unsigned SuccessLength = 12;

  localparam logic [CountWidth-1:0] CountMax  = '1;
  localparam logic [CountWidth-1:0] LengthRst = CountWidth'(8);

  localparam logic [7:0] EBit      = 8'h80;
  localparam logic [7:0] TBitRapid = 8'h40;
  localparam logic [7:0] T2Bit     = 8'h20;

  typedef enum logic [1:0] {
    CMD_BACKOFF = 2'd0,
    CMD_RAR     = 2'd1,
    CMD_SUCCESS = 2'd2,
    CMD_PAD     = 2'd3
  } rmpe_cmd_e;

  typedef struct packed {
    rmpe_cmd_e    cmd;
    logic         is_last;
    logic [5:0]   rapid_or_backoff;
    logic [11:0]  timing_advance;
    logic         freq_hop;
    logic [13:0]  freq_alloc_or_pucch;
    logic [3:0]   time_alloc_or_harq;
    logic [3:0]   mcs;
    logic [2:0]   tpc;
    logic         csi_request;
    logic [15:0]  rnti;
    logic [47:0]  contention_id;
  } rmpe_item_t;

endpackage

### hdl/rar_mac_pdu_encoder_core.sv
// Random access response MAC PDU encoder: one subPDU per transaction in, bytes out.
// First byte: the item is registered on acceptance, then its first byte is registered at the output.
// Throughput: one byte per cycle while the output is not stalled; an item is 1, 8 or 12 bytes
// (backoff or pad, RAR, successRAR); a pad item when the PDU is full is dropped with no byte.
// Reset (rst_ni low, asynchronous): byte count 0, pdu_length 8, pipeline empty.
// Depends on rmpe_pkg.
module rar_mac_pdu_encoder_core #(
  parameter int unsigned MAX_PDU_BYTES = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [12:0]  cfg_pdu_length_i,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [1:0]   command_i,
  input  logic         is_last_subpdu_i,
  input  logic [5:0]   rapid_or_backoff_i,
  input  logic [11:0]  timing_advance_i,
  input  logic         freq_hop_i,
  input  logic [13:0]  freq_alloc_or_pucch_i,
  input  logic [3:0]   time_alloc_or_harq_i,
  input  logic [3:0]   mcs_i,
  input  logic [2:0]   tpc_i,
  input  logic         csi_request_i,
  input  logic [15:0]  rnti_i,
  input  logic [47:0]  contention_id_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [7:0]   data_byte_o,
  output logic         last_of_item_o,
  output logic         pdu_end_o,
  output logic         overflow_o
);

  localparam int unsigned CW = rmpe_pkg::CountWidth;
  localparam int unsigned IW = rmpe_pkg::IdxWidth;

  logic [CW-1:0] pdu_length_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] eff_len;
  logic [CW:0]   count_inc;

  rmpe_pkg::rmpe_item_t item_q;
  logic                 busy_q;
  logic [IW-1:0]        idx_q;

  logic       out_valid_q;
  logic [7:0] data_q;
  logic       last_q, pdu_end_q, overflow_q;

  logic [7:0]    bytes [rmpe_pkg::MaxBytes];
  logic [IW-1:0] last_idx;
  logic          is_pad, drop, can_load, emit, fire, is_final, finish, in_accept;
  logic [7:0]    ebit;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pdu_length_q <= rmpe_pkg::LengthRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      pdu_length_q <= cfg_pdu_length_i;
    end
  end

  always_comb begin
    if (32'(pdu_length_q) > MAX_PDU_BYTES) begin
      eff_len = CW'(MAX_PDU_BYTES);
    end else begin
      eff_len = pdu_length_q;
    end
  end

  // Assemble the bytes of the held subPDU
  always_comb begin
    ebit = item_q.is_last ? 8'h00 : rmpe_pkg::EBit;
    for (int k = 0; k < rmpe_pkg::MaxBytes; k++) begin
      bytes[k] = 8'h00;
    end
    last_idx = '0;
    unique case (item_q.cmd)
      rmpe_pkg::CMD_BACKOFF: begin
        bytes[0] = ebit | {4'h0, item_q.rapid_or_backoff[3:0]};
      end
      rmpe_pkg::CMD_RAR: begin
        last_idx = IW'(rmpe_pkg::RarLength - 1);
        bytes[0] = ebit | rmpe_pkg::TBitRapid | {2'b00, item_q.rapid_or_backoff};
        bytes[1] = {1'b0, item_q.timing_advance[11:5]};
        bytes[2] = {item_q.timing_advance[4:0], item_q.freq_hop,
                    item_q.freq_alloc_or_pucch[13:12]};
        bytes[3] = item_q.freq_alloc_or_pucch[11:4];
        bytes[4] = {item_q.freq_alloc_or_pucch[3:0], item_q.time_alloc_or_harq};
        bytes[5] = {item_q.mcs, item_q.tpc, item_q.csi_request};
        bytes[6] = item_q.rnti[15:8];
        bytes[7] = item_q.rnti[7:0];
      end
      rmpe_pkg::CMD_SUCCESS: begin
        last_idx = IW'(rmpe_pkg::SuccessLength - 1);
        bytes[0]  = ebit | rmpe_pkg::T2Bit;
        bytes[1]  = item_q.contention_id[47:40];
        bytes[2]  = item_q.contention_id[39:32];
        bytes[3]  = item_q.contention_id[31:24];
        bytes[4]  = item_q.contention_id[23:16];
        bytes[5]  = item_q.contention_id[15:8];
        bytes[6]  = item_q.contention_id[7:0];
        bytes[7]  = {3'b000, item_q.tpc[1:0], item_q.time_alloc_or_harq[2:0]};
        bytes[8]  = {item_q.freq_alloc_or_pucch[3:0], item_q.timing_advance[11:8]};
        bytes[9]  = item_q.timing_advance[7:0];
        bytes[10] = item_q.rnti[15:8];
        bytes[11] = item_q.rnti[7:0];
      end
      rmpe_pkg::CMD_PAD: begin
        bytes[0] = 8'h00;
      end
      default: begin
        bytes[0] = 8'h00;
      end
    endcase
  end

  assign is_pad    = (item_q.cmd == rmpe_pkg::CMD_PAD);
  assign drop      = busy_q && is_pad && (count_q >= eff_len);
  assign can_load  = !out_valid_q || !out_stall_i;
  assign emit      = busy_q && !drop && can_load;
  assign fire      = drop || emit;
  assign is_final  = (idx_q == last_idx);
  assign finish    = fire && (drop || is_final);
  assign in_stall_o = busy_q && !finish;
  assign in_accept = in_valid_i && !in_stall_o;
  assign count_inc = {1'b0, count_q} + (CW+1)'(1);

  always_comb begin
    count_d = count_q;
    if (drop) begin
      count_d = '0;
    end else if (emit) begin
      if (is_pad && (count_inc[CW-1:0] == eff_len)) begin
        count_d = '0;
      end else if (count_q != rmpe_pkg::CountMax) begin
        count_d = count_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_accept) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (finish) begin
        busy_q <= 1'b0;
        idx_q  <= '0;
      end else if (emit) begin
        idx_q <= idx_q + IW'(1);
      end
      if (can_load) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= '{cmd: rmpe_pkg::rmpe_cmd_e'(command_i),
                  is_last: is_last_subpdu_i,
                  rapid_or_backoff: rapid_or_backoff_i,
                  timing_advance: timing_advance_i,
                  freq_hop: freq_hop_i,
                  freq_alloc_or_pucch: freq_alloc_or_pucch_i,
                  time_alloc_or_harq: time_alloc_or_harq_i,
                  mcs: mcs_i,
                  tpc: tpc_i,
                  csi_request: csi_request_i,
                  rnti: rnti_i,
                  contention_id: contention_id_i};
    end
    if (emit) begin
      data_q     <= bytes[idx_q];
      last_q     <= is_final;
      pdu_end_q  <= (count_inc == {1'b0, eff_len});
      overflow_q <= (count_q >= eff_len);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign data_byte_o    = data_q;
  assign last_of_item_o = last_q;
  assign pdu_end_o      = pdu_end_q;
  assign overflow_o     = overflow_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IW'(rmpe_pkg::MaxBytes - 1))
    else $error("byte index out of range");

  a_idx_multi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && idx_q != '0) |->
      (item_q.cmd == rmpe_pkg::CMD_RAR || item_q.cmd == rmpe_pkg::CMD_SUCCESS))
    else $error("multi-byte index on single-byte item");

  a_drop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop |=> (count_q == '0) && !$past(emit))
    else $error("full pad did not clear count");

  a_pad_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && is_pad && count_inc == {1'b0, eff_len}) |=> (count_q == '0))
    else $error("completing pad did not clear count");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && busy_q) |-> finish)
    else $error("item accepted over one in progress");

endmodule
